/* rtl/core/mcl_pkg.sv */
// Shared types, constants and the sequencer microprogram for the ladder unit.
package mcl_pkg;

  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned PC_W = 7;

  // Configuration register indexes
  typedef enum logic {
    CFG_MODULUS = 1'b0,
    CFG_A24     = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_MUL   = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_MOV, OP_JZ, OP_JCZ, OP_JNB,
    OP_JMP, OP_CALL, OP_RET, OP_NORM, OP_SHIFT, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    RG_X0, RG_Z0, RG_A24, RG_X1, RG_Z1, RG_X2, RG_Z2, RG_TX,
    RG_TZ, RG_UX, RG_UZ, RG_S, RG_D, RG_W, RG_V
  } reg_e;

  // Register-file operands share their codes with reg_e; the rest are fixed sources
  typedef enum logic [4:0] {
    SR_X0 = 5'd0, SR_Z0 = 5'd1, SR_A24 = 5'd2, SR_X1 = 5'd3, SR_Z1 = 5'd4,
    SR_X2 = 5'd5, SR_Z2 = 5'd6, SR_TX = 5'd7, SR_TZ = 5'd8, SR_UX = 5'd9,
    SR_UZ = 5'd10, SR_S = 5'd11, SR_D = 5'd12, SR_W = 5'd13, SR_V = 5'd14,
    SR_ONE = 5'd16, SR_BX = 5'd17, SR_BZ = 5'd18, SR_BA = 5'd19, SR_ZERO = 5'd20
  } src_e;

  typedef struct packed {
    op_e             op;
    reg_e            dst;
    src_e            sa;
    src_e            sb;
    logic [PC_W-1:0] tgt;
  } instr_t;

  localparam logic [PC_W-1:0] L_LOOP  = PC_W'(14);
  localparam logic [PC_W-1:0] L_RETB  = PC_W'(31);
  localparam logic [PC_W-1:0] L_RETA  = PC_W'(34);
  localparam logic [PC_W-1:0] L_ADBL  = PC_W'(37);
  localparam logic [PC_W-1:0] L_AEND  = PC_W'(40);
  localparam logic [PC_W-1:0] L_NOSW1 = PC_W'(49);
  localparam logic [PC_W-1:0] L_NOSW2 = PC_W'(63);
  localparam logic [PC_W-1:0] L_FIN   = PC_W'(65);
  localparam logic [PC_W-1:0] L_ONE   = PC_W'(66);
  localparam logic [PC_W-1:0] L_ZERO  = PC_W'(67);
  localparam logic [PC_W-1:0] L_DBL   = PC_W'(68);
  localparam logic [PC_W-1:0] L_DRET  = PC_W'(78);
  localparam logic [PC_W-1:0] NO_TGT  = '0;

  function automatic instr_t mk(input op_e op, input reg_e dst, input src_e sa,
                                input src_e sb, input logic [PC_W-1:0] tgt);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.sa  = sa;
    i.sb  = sb;
    i.tgt = tgt;
    return i;
  endfunction

  // Microprogram: operand reduction, scalar normalisation, ladder loop, doubling routine
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      7'd0:  i = mk(OP_MUL,   RG_X0,  SR_ONE,  SR_BX,   NO_TGT);
      7'd1:  i = mk(OP_MUL,   RG_Z0,  SR_ONE,  SR_BZ,   NO_TGT);
      7'd2:  i = mk(OP_MUL,   RG_A24, SR_ONE,  SR_BA,   NO_TGT);
      7'd3:  i = mk(OP_NORM,  RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
      7'd4:  i = mk(OP_JCZ,   RG_X0,  SR_ZERO, SR_ZERO, L_ZERO);
      7'd5:  i = mk(OP_SHIFT, RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
      7'd6:  i = mk(OP_JCZ,   RG_X0,  SR_ZERO, SR_ZERO, L_ONE);
      7'd7:  i = mk(OP_MOV,   RG_TX,  SR_X0,   SR_ZERO, NO_TGT);
      7'd8:  i = mk(OP_MOV,   RG_TZ,  SR_Z0,   SR_ZERO, NO_TGT);
      7'd9:  i = mk(OP_CALL,  RG_X0,  SR_ZERO, SR_ZERO, L_DBL);
      7'd10: i = mk(OP_MOV,   RG_X2,  SR_TX,   SR_ZERO, NO_TGT);
      7'd11: i = mk(OP_MOV,   RG_Z2,  SR_TZ,   SR_ZERO, NO_TGT);
      7'd12: i = mk(OP_MOV,   RG_X1,  SR_X0,   SR_ZERO, NO_TGT);
      7'd13: i = mk(OP_MOV,   RG_Z1,  SR_Z0,   SR_ZERO, NO_TGT);
      7'd14: i = mk(OP_JCZ,   RG_X0,  SR_ZERO, SR_ZERO, L_FIN);
      7'd15: i = mk(OP_JZ,    RG_X0,  SR_Z1,   SR_ZERO, L_RETB);
      7'd16: i = mk(OP_JZ,    RG_X0,  SR_Z2,   SR_ZERO, L_RETA);
      7'd17: i = mk(OP_JZ,    RG_X0,  SR_Z0,   SR_ZERO, L_ADBL);
      7'd18: i = mk(OP_SUB,   RG_S,   SR_X2,   SR_Z2,   NO_TGT);
      7'd19: i = mk(OP_ADD,   RG_D,   SR_X1,   SR_Z1,   NO_TGT);
      7'd20: i = mk(OP_MUL,   RG_S,   SR_S,    SR_D,    NO_TGT);
      7'd21: i = mk(OP_SUB,   RG_D,   SR_X1,   SR_Z1,   NO_TGT);
      7'd22: i = mk(OP_ADD,   RG_W,   SR_X2,   SR_Z2,   NO_TGT);
      7'd23: i = mk(OP_MUL,   RG_D,   SR_D,    SR_W,    NO_TGT);
      7'd24: i = mk(OP_ADD,   RG_W,   SR_S,    SR_D,    NO_TGT);
      7'd25: i = mk(OP_SUB,   RG_D,   SR_D,    SR_S,    NO_TGT);
      7'd26: i = mk(OP_MUL,   RG_W,   SR_W,    SR_W,    NO_TGT);
      7'd27: i = mk(OP_MUL,   RG_D,   SR_D,    SR_D,    NO_TGT);
      7'd28: i = mk(OP_MUL,   RG_TX,  SR_Z0,   SR_W,    NO_TGT);
      7'd29: i = mk(OP_MUL,   RG_TZ,  SR_X0,   SR_D,    NO_TGT);
      7'd30: i = mk(OP_JMP,   RG_X0,  SR_ZERO, SR_ZERO, L_AEND);
      7'd31: i = mk(OP_MOV,   RG_TX,  SR_X2,   SR_ZERO, NO_TGT);
      7'd32: i = mk(OP_MOV,   RG_TZ,  SR_Z2,   SR_ZERO, NO_TGT);
      7'd33: i = mk(OP_JMP,   RG_X0,  SR_ZERO, SR_ZERO, L_AEND);
      7'd34: i = mk(OP_MOV,   RG_TX,  SR_X1,   SR_ZERO, NO_TGT);
      7'd35: i = mk(OP_MOV,   RG_TZ,  SR_Z1,   SR_ZERO, NO_TGT);
      7'd36: i = mk(OP_JMP,   RG_X0,  SR_ZERO, SR_ZERO, L_AEND);
      7'd37: i = mk(OP_MOV,   RG_TX,  SR_X1,   SR_ZERO, NO_TGT);
      7'd38: i = mk(OP_MOV,   RG_TZ,  SR_Z1,   SR_ZERO, NO_TGT);
      7'd39: i = mk(OP_CALL,  RG_X0,  SR_ZERO, SR_ZERO, L_DBL);
      7'd40: i = mk(OP_MOV,   RG_UX,  SR_TX,   SR_ZERO, NO_TGT);
      7'd41: i = mk(OP_MOV,   RG_UZ,  SR_TZ,   SR_ZERO, NO_TGT);
      7'd42: i = mk(OP_JNB,   RG_X0,  SR_ZERO, SR_ZERO, L_NOSW1);
      7'd43: i = mk(OP_MOV,   RG_TX,  SR_X1,   SR_ZERO, NO_TGT);
      7'd44: i = mk(OP_MOV,   RG_TZ,  SR_Z1,   SR_ZERO, NO_TGT);
      7'd45: i = mk(OP_MOV,   RG_X1,  SR_X2,   SR_ZERO, NO_TGT);
      7'd46: i = mk(OP_MOV,   RG_Z1,  SR_Z2,   SR_ZERO, NO_TGT);
      7'd47: i = mk(OP_MOV,   RG_X2,  SR_TX,   SR_ZERO, NO_TGT);
      7'd48: i = mk(OP_MOV,   RG_Z2,  SR_TZ,   SR_ZERO, NO_TGT);
      7'd49: i = mk(OP_MOV,   RG_TX,  SR_X1,   SR_ZERO, NO_TGT);
      7'd50: i = mk(OP_MOV,   RG_TZ,  SR_Z1,   SR_ZERO, NO_TGT);
      7'd51: i = mk(OP_CALL,  RG_X0,  SR_ZERO, SR_ZERO, L_DBL);
      7'd52: i = mk(OP_MOV,   RG_X1,  SR_TX,   SR_ZERO, NO_TGT);
      7'd53: i = mk(OP_MOV,   RG_Z1,  SR_TZ,   SR_ZERO, NO_TGT);
      7'd54: i = mk(OP_MOV,   RG_X2,  SR_UX,   SR_ZERO, NO_TGT);
      7'd55: i = mk(OP_MOV,   RG_Z2,  SR_UZ,   SR_ZERO, NO_TGT);
      7'd56: i = mk(OP_JNB,   RG_X0,  SR_ZERO, SR_ZERO, L_NOSW2);
      7'd57: i = mk(OP_MOV,   RG_TX,  SR_X1,   SR_ZERO, NO_TGT);
      7'd58: i = mk(OP_MOV,   RG_TZ,  SR_Z1,   SR_ZERO, NO_TGT);
      7'd59: i = mk(OP_MOV,   RG_X1,  SR_X2,   SR_ZERO, NO_TGT);
      7'd60: i = mk(OP_MOV,   RG_Z1,  SR_Z2,   SR_ZERO, NO_TGT);
      7'd61: i = mk(OP_MOV,   RG_X2,  SR_TX,   SR_ZERO, NO_TGT);
      7'd62: i = mk(OP_MOV,   RG_Z2,  SR_TZ,   SR_ZERO, NO_TGT);
      7'd63: i = mk(OP_SHIFT, RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
      7'd64: i = mk(OP_JMP,   RG_X0,  SR_ZERO, SR_ZERO, L_LOOP);
      7'd65: i = mk(OP_OUT,   RG_X0,  SR_X1,   SR_Z1,   NO_TGT);
      7'd66: i = mk(OP_OUT,   RG_X0,  SR_X0,   SR_Z0,   NO_TGT);
      7'd67: i = mk(OP_OUT,   RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
      7'd68: i = mk(OP_JZ,    RG_X0,  SR_TZ,   SR_ZERO, L_DRET);
      7'd69: i = mk(OP_ADD,   RG_S,   SR_TX,   SR_TZ,   NO_TGT);
      7'd70: i = mk(OP_MUL,   RG_S,   SR_S,    SR_S,    NO_TGT);
      7'd71: i = mk(OP_SUB,   RG_D,   SR_TX,   SR_TZ,   NO_TGT);
      7'd72: i = mk(OP_MUL,   RG_D,   SR_D,    SR_D,    NO_TGT);
      7'd73: i = mk(OP_MUL,   RG_TX,  SR_S,    SR_D,    NO_TGT);
      7'd74: i = mk(OP_SUB,   RG_W,   SR_S,    SR_D,    NO_TGT);
      7'd75: i = mk(OP_MUL,   RG_V,   SR_W,    SR_A24,  NO_TGT);
      7'd76: i = mk(OP_ADD,   RG_V,   SR_V,    SR_D,    NO_TGT);
      7'd77: i = mk(OP_MUL,   RG_TZ,  SR_W,    SR_V,    NO_TGT);
      7'd78: i = mk(OP_RET,   RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
      default: i = mk(OP_RET, RG_X0,  SR_ZERO, SR_ZERO, NO_TGT);
    endcase
    return i;
  endfunction

endpackage

/* rtl/core/montgomery_curve_ladder_mod_n_unit.sv */
// Montgomery-curve x:z ladder: scalar times point modulo a configured n.
// Sequence: each microinstruction is fetched, then executed; a modular multiply runs
//   bit-serially. The unit reduces the operands, shifts the scalar up to its top bit,
//   then runs one ladder step per lower scalar bit.
// Throughput: one transaction at a time; the single bit-serial multiplier sets the pace.
// Reset: asynchronous, active low; clears the sequencer and output valid, modulus to 2,
//   curve constant to 0. The register file needs no reset.
module montgomery_curve_ladder_mod_n_unit #(
  parameter int unsigned WORD_BITS = mcl_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] base_x_i,
  input  logic [WORD_BITS-1:0] base_z_i,
  input  logic [WORD_BITS-1:0] scalar_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] result_x_o,
  output logic [WORD_BITS-1:0] result_z_o
);
  import mcl_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned CNT_W = $clog2(W + 1);
  localparam int unsigned RF_D  = 16;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d, link_q, link_d;
  instr_t            ins_q, ins_d;
  logic [W-1:0]      modulus_q, a24_q;
  logic [W-1:0]      bx_q, bx_d, bz_q, bz_d, k_q, k_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [W-1:0]      mul_a_q, mul_a_d, mul_b_q, mul_b_d, mul_r_q, mul_r_d;
  logic [CNT_W-1:0]  mul_cnt_q, mul_cnt_d;
  logic [W-1:0]      res_x_q, res_x_d, res_z_q, res_z_d;
  logic              out_valid_q, out_valid_d;

  // Register file: one write port, two registered read ports
  logic [W-1:0]      rf_q [RF_D];
  logic [W-1:0]      rd_a_q, rd_b_q;
  logic              rf_we;
  logic [3:0]        rf_wa;
  logic [W-1:0]      rf_wd;
  logic              fetch;

  logic [W-1:0]      n_eff, op_a, op_b, add_res, sub_res, mul_next;
  logic [W:0]        n_x, add_sum, dbl_sum, dbl_red, acc_sum;

  assign fetch = (state_q == ST_FETCH);
  assign ins_d = prog_rom(pc_q);

  // A modulus of zero behaves as one
  assign n_eff = (modulus_q == '0) ? W'(1) : modulus_q;
  assign n_x   = {1'b0, n_eff};

  function automatic logic [W-1:0] pick(input src_e s, input logic [W-1:0] rd,
                                        input logic [W-1:0] bx, input logic [W-1:0] bz,
                                        input logic [W-1:0] ba);
    logic [W-1:0] v;
    unique case (s)
      SR_ONE:  v = W'(1);
      SR_BX:   v = bx;
      SR_BZ:   v = bz;
      SR_BA:   v = ba;
      SR_ZERO: v = '0;
      default: v = rd;
    endcase
    return v;
  endfunction

  assign op_a = pick(ins_q.sa, rd_a_q, bx_q, bz_q, a24_q);
  assign op_b = pick(ins_q.sb, rd_b_q, bx_q, bz_q, a24_q);

  // Modular add and subtract of reduced operands
  assign add_sum = {1'b0, op_a} + {1'b0, op_b};
  assign add_res = (add_sum >= n_x) ? W'(add_sum - n_x) : add_sum[W-1:0];
  assign sub_res = (op_a >= op_b) ? (op_a - op_b) : (op_a - op_b + n_eff);

  // One bit of the shift-and-add multiplier: double, then add the multiplicand on a set bit
  assign dbl_sum  = {mul_r_q, 1'b0};
  assign dbl_red  = (dbl_sum >= n_x) ? (dbl_sum - n_x) : dbl_sum;
  assign acc_sum  = dbl_red + {1'b0, mul_a_q};
  always_comb begin
    if (!mul_b_q[W-1]) begin
      mul_next = dbl_red[W-1:0];
    end else if (acc_sum >= n_x) begin
      mul_next = W'(acc_sum - n_x);
    end else begin
      mul_next = acc_sum[W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    link_d      = link_q;
    bx_d        = bx_q;
    bz_d        = bz_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_r_d     = mul_r_q;
    mul_cnt_d   = mul_cnt_q;
    res_x_d     = res_x_q;
    res_z_d     = res_z_q;
    out_valid_d = out_valid_q;
    rf_we       = 1'b0;
    rf_wa       = ins_q.dst;
    rf_wd       = op_a;

    // Drop the result once the downstream side takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bx_d    = base_x_i;
          bz_d    = base_z_i;
          k_d     = scalar_i;
          cnt_d   = CNT_W'(W);
          pc_d    = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_FETCH;
        pc_d    = pc_q + PC_W'(1);
        unique case (ins_q.op)
          OP_MUL: begin
            mul_a_d   = op_a;
            mul_b_d   = op_b;
            mul_r_d   = '0;
            mul_cnt_d = CNT_W'(W);
            pc_d      = pc_q;
            state_d   = ST_MUL;
          end
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = add_res;
          end
          OP_SUB: begin
            rf_we = 1'b1;
            rf_wd = sub_res;
          end
          OP_MOV: begin
            rf_we = 1'b1;
          end
          OP_JZ: begin
            if (op_a == '0) begin
              pc_d = ins_q.tgt;
            end
          end
          OP_JCZ: begin
            if (cnt_q == '0) begin
              pc_d = ins_q.tgt;
            end
          end
          OP_JNB: begin
            if (!k_q[W-1]) begin
              pc_d = ins_q.tgt;
            end
          end
          OP_JMP: begin
            pc_d = ins_q.tgt;
          end
          OP_CALL: begin
            link_d = pc_q + PC_W'(1);
            pc_d   = ins_q.tgt;
          end
          OP_RET: begin
            pc_d = link_q;
          end
          OP_NORM: begin
            // Hold here, shifting one bit a cycle, until the top bit leads or the count runs out
            if (!k_q[W-1] && (cnt_q != '0)) begin
              k_d     = {k_q[W-2:0], 1'b0};
              cnt_d   = cnt_q - CNT_W'(1);
              pc_d    = pc_q;
              state_d = ST_EXEC;
            end
          end
          OP_SHIFT: begin
            k_d   = {k_q[W-2:0], 1'b0};
            cnt_d = cnt_q - CNT_W'(1);
          end
          OP_OUT: begin
            if (!out_valid_q || !out_stall_i) begin
              res_x_d     = op_a;
              res_z_d     = op_b;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              pc_d    = pc_q;
              state_d = ST_EXEC;
            end
          end
          default: begin
            pc_d = link_q;
          end
        endcase
      end
      ST_MUL: begin
        mul_r_d   = mul_next;
        mul_b_d   = {mul_b_q[W-2:0], 1'b0};
        mul_cnt_d = mul_cnt_q - CNT_W'(1);
        if (mul_cnt_q == CNT_W'(1)) begin
          rf_we   = 1'b1;
          rf_wd   = mul_next;
          pc_d    = pc_q + PC_W'(1);
          state_d = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      link_q      <= '0;
      out_valid_q <= 1'b0;
      modulus_q   <= W'(2);
      a24_q       <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      link_q      <= link_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODULUS: modulus_q <= cfg_data_i;
          CFG_A24:     a24_q     <= cfg_data_i;
          default:     a24_q     <= a24_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q      <= bx_d;
    bz_q      <= bz_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_r_q   <= mul_r_d;
    mul_cnt_q <= mul_cnt_d;
    res_x_q   <= res_x_d;
    res_z_q   <= res_z_d;
    if (fetch) begin
      ins_q <= ins_d;
    end
  end

  // Register file write and registered reads
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
    if (fetch) begin
      rd_a_q <= rf_q[ins_d.sa[3:0]];
      rd_b_q <= rf_q[ins_d.sb[3:0]];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_x_o  = res_x_q;
  assign result_z_o  = res_z_q;

endmodule

/* rtl/core/mcl_chk.sv */
// Port-level checker for the ladder unit and its bind statement.
module mcl_chk #(
  parameter int unsigned WORD_BITS = mcl_pkg::WORD_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_BITS-1:0] result_x_o,
  input logic [WORD_BITS-1:0] result_z_o
);

  // Hold the result while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_x_o) && $stable(result_z_o))
    else $error("result dropped or changed under stall");

  // A new transaction makes the unit busy at once
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit not busy after accepting a transaction");

  // A fresh result frees the input side
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("input still stalled after result issued");

  // A result only appears after busy work
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in progress");

endmodule

bind montgomery_curve_ladder_mod_n_unit mcl_chk #(.WORD_BITS(WORD_BITS)) u_mcl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_x_o  (result_x_o),
  .result_z_o  (result_z_o)
);

/* dv/tb_montgomery_curve_ladder_mod_n_unit.sv */
// Self-checking testbench for the Montgomery x:z ladder unit.
`timescale 1ns / 1ps

module tb_montgomery_curve_ladder_mod_n_unit;
  import mcl_pkg::*;

  typedef logic [63:0] word_t;

  // One row of the directed table: an optional register write ahead of the transaction,
  // then the transaction itself, with a typed-in result where it is obvious
  typedef struct {
    bit    wr_cfg;
    word_t modulus;
    word_t a24;
    word_t x;
    word_t z;
    word_t k;
    bit    typed;
    word_t ex;
    word_t ez;
  } row_t;

  typedef struct {
    word_t x;
    word_t z;
  } point_t;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  cfg_idx_i;
  word_t cfg_data_i;
  logic  in_valid_i;
  logic  in_stall_o;
  word_t base_x_i;
  word_t base_z_i;
  word_t scalar_i;
  logic  out_valid_o;
  logic  out_stall_i;
  word_t result_x_o;
  word_t result_z_o;

  montgomery_curve_ladder_mod_n_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_x_i    (base_x_i),
    .base_z_i    (base_z_i),
    .scalar_i    (scalar_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_x_o  (result_x_o),
    .result_z_o  (result_z_o)
  );

  // Shadow copy of the configuration registers, as reset leaves them
  word_t  shadow_modulus = 64'd2;
  word_t  shadow_a24     = 64'd0;
  point_t product_q[$];
  int     fail_count     = 0;
  int     sent_count     = 0;
  int     seen_count     = 0;
  int     cfg_count      = 0;
  int     send_idle_pct  = 0;
  int     recv_idle_pct  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Modular arithmetic on residues below n
  // ---------------------------------------------------------------------------
  function automatic word_t mod_add(word_t a, word_t b, word_t n);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[63:0];
  endfunction

  function automatic word_t mod_sub(word_t a, word_t b, word_t n);
    return (a >= b) ? a - b : a - b + n;
  endfunction

  function automatic word_t mod_mul(word_t a, word_t b, word_t n);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, n};
    return p[63:0];
  endfunction

  // Doubling; a point at infinity (z zero) keeps its x
  function automatic point_t dbl_point(point_t p, word_t a24, word_t n);
    point_t r;
    word_t  s, d, w, t;
    if (p.z == 0) begin
      r.x = p.x;
      r.z = 0;
      return r;
    end
    s   = mod_add(p.x, p.z, n);
    s   = mod_mul(s, s, n);
    d   = mod_sub(p.x, p.z, n);
    d   = mod_mul(d, d, n);
    r.x = mod_mul(s, d, n);
    w   = mod_sub(s, d, n);
    t   = mod_add(mod_mul(w, a24, n), d, n);
    r.z = mod_mul(w, t, n);
    return r;
  endfunction

  // Differential addition of a and b with difference dp
  function automatic point_t add_points(point_t a, point_t b, point_t dp, word_t a24,
                                        word_t n);
    point_t r;
    word_t  p, q, s, d;
    if (a.z == 0) return b;
    if (b.z == 0) return a;
    if (dp.z == 0) return dbl_point(a, a24, n);
    p   = mod_mul(mod_sub(b.x, b.z, n), mod_add(a.x, a.z, n), n);
    q   = mod_mul(mod_sub(a.x, a.z, n), mod_add(b.x, b.z, n), n);
    s   = mod_add(p, q, n);
    d   = mod_sub(q, p, n);
    r.x = mod_mul(dp.z, mod_mul(s, s, n), n);
    r.z = mod_mul(dp.x, mod_mul(d, d, n), n);
    return r;
  endfunction

  // k times (x:z) under the current shadow configuration
  function automatic point_t ladder_product(word_t x, word_t z, word_t k);
    point_t base, lo, hi, sum;
    word_t  n, a24;
    int     top;
    n = (shadow_modulus == 0) ? 64'd1 : shadow_modulus;
    base.x = x % n;
    base.z = z % n;
    a24 = shadow_a24 % n;
    if (k == 0) begin
      lo.x = 0;
      lo.z = 0;
      return lo;
    end
    if (k == 1) return base;
    top = 63;
    while (top > 0 && !k[top]) top--;
    lo = base;
    hi = dbl_point(base, a24, n);
    for (int i = top - 1; i >= 0; i--) begin
      sum = add_points(lo, hi, base, a24, n);
      if (k[i]) begin
        hi = dbl_point(hi, a24, n);
        lo = sum;
      end else begin
        lo = dbl_point(lo, a24, n);
        hi = sum;
      end
    end
    return lo;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare against the oldest expected product
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_count++;
      if (product_q.size() == 0) begin
        $error("unexpected result x=%h z=%h", result_x_o, result_z_o);
        fail_count++;
      end else begin
        exp_pt = product_q.pop_front();
        if (result_x_o !== exp_pt.x) begin
          $error("result_x expected %h actual %h", exp_pt.x, result_x_o);
          fail_count++;
        end
        if (result_z_o !== exp_pt.z) begin
          $error("result_z expected %h actual %h", exp_pt.z, result_z_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Drop valid, hold until every outstanding product is back, then let the
  // sequencer settle before returning at a falling edge
  task automatic drain();
    in_valid_i = 1'b0;
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, word_t value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    if (idx == CFG_MODULUS) shadow_modulus = value;
    else shadow_a24 = value;
    cfg_count++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic reconfigure(word_t modulus, word_t a24);
    drain();
    write_reg(CFG_MODULUS, modulus);
    write_reg(CFG_A24, a24);
  endtask

  // Present one transaction at a falling edge and advance until it is taken.
  // Valid stays high into the next transaction unless the sender idles.
  task automatic send_point(word_t x, word_t z, word_t k, bit typed, word_t ex,
                            word_t ez);
    point_t exp_pt;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    base_x_i   = x;
    base_z_i   = z;
    scalar_i   = k;
    if (typed) begin
      exp_pt.x = ex;
      exp_pt.z = ez;
    end else begin
      exp_pt = ladder_product(x, z, k);
    end
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    product_q.push_back(exp_pt);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Mostly short scalars keep the run short; a few span all 64 bits
  function automatic word_t rand_scalar();
    word_t k;
    k = rand_word();
    if ($urandom_range(9) != 0) k = k >> $urandom_range(54, 63);
    return k;
  endfunction

  localparam word_t PRIME64 = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam word_t ALL1    = 64'hFFFF_FFFF_FFFF_FFFF;

  // Directed rows: reset configuration first, then prime, all-ones, zero, unit and 15 moduli
  row_t directed[] = '{
    '{0, 0, 0, 64'd5, 64'd7, 64'd0, 1, 64'd0, 64'd0},
    '{0, 0, 0, 64'd5, 64'd7, 64'd1, 1, 64'd1, 64'd1},
    '{0, 0, 0, ALL1, 64'd0, 64'd1, 1, 64'd1, 64'd0},
    '{0, 0, 0, 64'd3, 64'd1, 64'd5, 0, 0, 0},
    '{1, PRIME64, 64'd5, ALL1, ALL1, 64'd0, 1, 64'd0, 64'd0},
    '{0, 0, 0, 64'd9, 64'd1, 64'd1, 1, 64'd9, 64'd1},
    '{0, 0, 0, ALL1, ALL1, 64'd1, 0, 0, 0},
    '{0, 0, 0, 64'd9, 64'd1, 64'd2, 0, 0, 0},
    '{0, 0, 0, 64'd9, 64'd1, 64'd3, 0, 0, 0},
    '{0, 0, 0, 64'd9, 64'd0, 64'd6, 0, 0, 0},
    '{0, 0, 0, 64'd0, 64'd1, 64'd7, 0, 0, 0},
    '{0, 0, 0, 64'd9, 64'd1, ALL1, 0, 0, 0},
    '{0, 0, 0, 64'd2, 64'd3, 64'h8000_0000_0000_0000, 0, 0, 0},
    '{1, ALL1, ALL1, 64'd4, 64'd1, 64'd11, 0, 0, 0},
    '{0, 0, 0, ALL1, ALL1, 64'd1, 1, 64'd0, 64'd0},
    '{1, 64'd0, 64'd3, 64'd8, 64'd5, 64'd9, 1, 64'd0, 64'd0},
    '{1, 64'd1, 64'd0, ALL1, 64'd6, 64'd1, 1, 64'd0, 64'd0},
    '{1, 64'd15, 64'd4, 64'd2, 64'd1, 64'd12, 0, 0, 0},
    '{0, 0, 0, 64'd17, 64'd16, 64'd1, 1, 64'd2, 64'd1}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    word_t mod_set[6];
    word_t a24_set[6];
    int    idle_mode;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MODULUS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    base_x_i    = '0;
    base_z_i    = '0;
    scalar_i    = '0;
    out_stall_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part, no idling
    foreach (directed[r]) begin
      if (directed[r].wr_cfg) reconfigure(directed[r].modulus, directed[r].a24);
      send_point(directed[r].x, directed[r].z, directed[r].k, directed[r].typed,
                 directed[r].ex, directed[r].ez);
    end

    // Random part: six settings, extremes among them, each for 25 transactions
    mod_set[0] = PRIME64;            a24_set[0] = rand_word();
    mod_set[1] = ALL1;               a24_set[1] = ALL1;
    mod_set[2] = 64'd1000003;        a24_set[2] = 64'd0;
    mod_set[3] = rand_word() | 64'd1; a24_set[3] = rand_word();
    mod_set[4] = 64'd0;              a24_set[4] = rand_word();
    mod_set[5] = rand_word() & ~64'd1; a24_set[5] = rand_word();

    for (int ph = 0; ph < 6; ph++) begin
      reconfigure(mod_set[ph], a24_set[ph]);
      idle_mode = ph / 2;
      case (idle_mode)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < 25; i++) begin
        // Hold off once mid-phase until the pipe is empty
        if (ph == 1 && i == 12) begin
          in_valid_i = 1'b0;
          drain();
        end
        if ($urandom_range(3) == 0)
          send_point(rand_word(), rand_word(), rand_scalar(), 0, 0, 0);
        else
          send_point(rand_word() % (mod_set[ph] == 0 ? 64'd1 : mod_set[ph]),
                     rand_word() % (mod_set[ph] == 0 ? 64'd1 : mod_set[ph]),
                     rand_scalar(), 0, 0, 0);
      end
    end

    in_valid_i    = 1'b0;
    recv_idle_pct = 0;
    drain();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d transactions, %0d results, %0d register writes,", sent_count,
             seen_count, cfg_count);
    $display("reset, prime, all-ones, zero, unit and even moduli under three stall mixes.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
